// File: rtl/periodic_deadline_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Periodic deadline scheduler assertion macros
// Implication checks on the scheduler's own logic.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_DEADLINE_SCHEDULER_ASSERT_SVH
`define PERIODIC_DEADLINE_SCHEDULER_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define PDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pds assertion failed");
// next-cycle implication
`define PDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pds assertion failed");
`else
`define PDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/pds_pkg.sv
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants of the periodic deadline scheduler.
// ----------------------------------------------------------------------------
package pds_pkg;
    localparam int SLOTS   = 16;
    localparam int MAX_RES = 16;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int FI_W    = $clog2(MAX_RES);
    localparam int NF_W    = $clog2(MAX_RES + 1);
    localparam int DL_W    = 48;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [NF_W-1:0]  t_nf;

    localparam t_cnt SLOTS_CNT = t_cnt'(SLOTS);
    localparam t_nf  MAX_NF    = t_nf'(MAX_RES);
    localparam logic [31:0] TPM_RESET = 32'd60000000;

    typedef enum logic [1:0] {
        K_ADD    = 2'd0,
        K_REMOVE = 2'd1,
        K_TICK   = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]      channel;
        logic [15:0]     interval;
        logic [DL_W-1:0] deadline;
    } t_slot;

    typedef struct packed {
        logic  en;
        t_idx  addr;
        t_slot data;
    } t_wr_port;

    typedef enum logic [4:0] {
        S_IDLE, S_FIND_RD, S_FIND_CHK, S_MUL, S_SUM, S_INS_RD, S_INS_CHK,
        S_SHF_RD, S_SHF_WR, S_INS_WR, S_REM_RD, S_REM_WR, S_TICK_RD,
        S_TICK_CHK, S_FIN_RD, S_FIN_CHK, S_EMIT
    } t_state;
endpackage

// File: rtl/pds_slot_ram.sv
// ----------------------------------------------------------------------------
// pds_slot_ram
// Slot table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pds_slot_ram (
    input  logic              i_clk,
    input  pds_pkg::t_idx     i_rd_addr,
    output pds_pkg::t_slot    o_rd_data,
    input  pds_pkg::t_wr_port i_wr
);
    pds_pkg::t_slot mem [pds_pkg::SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= mem[i_rd_addr];
    end
endmodule

// File: rtl/periodic_deadline_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_deadline_scheduler
// Deadline-sorted table of periodic channels with add, remove and tick.
// ----------------------------------------------------------------------------
// One item at a time: busy is high from acceptance until the last result has
// been shown. The sorted table sits in a RAM with one write port and one
// registered read port, and every walk over it reads and then checks or
// writes one entry at a time. An add looks for a duplicate and then inserts in
// deadline order, a remove finds the entry and pulls the later ones down, and a
// tick moves each channel that falls due to its new place. Results then follow
// at one per cycle, each held for exactly one cycle under o_valid; the receiver
// cannot stall them. queue_nonempty and next_delay describe the table after
// the whole transaction and repeat on every result of it.
module periodic_deadline_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_channel_id,
    input  logic [15:0] i_interval_minutes,
    input  logic [47:0] i_now,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic        o_fired,
    output logic [7:0]  o_fired_channel,
    output logic        o_queue_nonempty,
    output logic [47:0] o_next_delay,
    output logic        o_last
);
`include "periodic_deadline_scheduler_assert.svh"

    pds_pkg::t_state   r_state, n_state;
    pds_pkg::t_cnt     r_count, n_count;
    pds_pkg::t_cnt     r_idx, n_idx;
    pds_pkg::t_cnt     r_pos, n_pos;
    pds_pkg::t_kind    r_kind, n_kind;
    logic [7:0]        r_id, n_id;
    logic [47:0]       r_now, n_now;
    logic [31:0]       r_tpm;
    pds_pkg::t_status  r_status, n_status;
    logic [7:0]        r_new_ch, n_new_ch;
    logic [15:0]       r_new_iv, n_new_iv;
    logic [47:0]       r_new_dl, n_new_dl;
    logic [47:0]       r_prod;
    pds_pkg::t_nf      r_nfired, n_nfired;
    pds_pkg::t_nf      r_emit, n_emit;
    logic [7:0]        r_fired [pds_pkg::MAX_RES];
    logic              fire_we;
    logic [47:0]       r_delay, n_delay;
    logic              r_nonempty, n_nonempty;
    logic [48:0]       sum;
    logic              emit_last;

    pds_pkg::t_idx     rd_addr;
    pds_pkg::t_slot    rd_data;
    pds_pkg::t_wr_port wr;

    pds_slot_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr      (wr)
    );

    assign sum       = {1'b0, r_now} + {1'b0, r_prod};
    assign emit_last = (r_nfired == '0) || (r_emit == r_nfired - pds_pkg::t_nf'(1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pds_pkg::S_IDLE: begin
                if (start) begin
                    unique case (pds_pkg::t_kind'(i_kind))
                        pds_pkg::K_ADD:    n_state = (i_interval_minutes == '0) ?
                                                     pds_pkg::S_FIN_RD : pds_pkg::S_FIND_RD;
                        pds_pkg::K_REMOVE: n_state = pds_pkg::S_FIND_RD;
                        pds_pkg::K_TICK:   n_state = pds_pkg::S_TICK_RD;
                        default:           n_state = pds_pkg::S_FIN_RD;
                    endcase
                end
            end
            pds_pkg::S_FIND_RD: begin
                if (r_idx < r_count) begin
                    n_state = pds_pkg::S_FIND_CHK;
                end else if (r_kind == pds_pkg::K_ADD && r_count < pds_pkg::SLOTS_CNT) begin
                    n_state = pds_pkg::S_MUL;
                end else begin
                    n_state = pds_pkg::S_FIN_RD;
                end
            end
            pds_pkg::S_FIND_CHK: begin
                if (rd_data.channel == r_id) begin
                    n_state = (r_kind == pds_pkg::K_ADD) ? pds_pkg::S_FIN_RD : pds_pkg::S_REM_RD;
                end else begin
                    n_state = pds_pkg::S_FIND_RD;
                end
            end
            pds_pkg::S_REM_RD: begin
                if (r_idx + pds_pkg::t_cnt'(1) < r_count) begin
                    n_state = pds_pkg::S_REM_WR;
                end else begin
                    n_state = (r_kind == pds_pkg::K_TICK) ? pds_pkg::S_MUL : pds_pkg::S_FIN_RD;
                end
            end
            pds_pkg::S_REM_WR:   n_state = pds_pkg::S_REM_RD;
            pds_pkg::S_MUL:      n_state = pds_pkg::S_SUM;
            pds_pkg::S_SUM:      n_state = pds_pkg::S_INS_RD;
            pds_pkg::S_INS_RD:   n_state = (r_idx < r_count) ? pds_pkg::S_INS_CHK
                                                              : pds_pkg::S_SHF_RD;
            pds_pkg::S_INS_CHK:  n_state = (r_new_dl < rd_data.deadline) ? pds_pkg::S_SHF_RD
                                                                          : pds_pkg::S_INS_RD;
            pds_pkg::S_SHF_RD:   n_state = (r_idx > r_pos) ? pds_pkg::S_SHF_WR
                                                            : pds_pkg::S_INS_WR;
            pds_pkg::S_SHF_WR:   n_state = pds_pkg::S_SHF_RD;
            pds_pkg::S_INS_WR:   n_state = (r_kind == pds_pkg::K_ADD) ? pds_pkg::S_FIN_RD
                                                                       : pds_pkg::S_TICK_RD;
            pds_pkg::S_TICK_RD:  n_state = (r_count == '0) ? pds_pkg::S_FIN_RD
                                                            : pds_pkg::S_TICK_CHK;
            pds_pkg::S_TICK_CHK: n_state = (rd_data.deadline < r_now) ? pds_pkg::S_REM_RD
                                                                       : pds_pkg::S_FIN_RD;
            pds_pkg::S_FIN_RD:   n_state = (r_count == '0) ? pds_pkg::S_EMIT
                                                            : pds_pkg::S_FIN_CHK;
            pds_pkg::S_FIN_CHK:  n_state = pds_pkg::S_EMIT;
            pds_pkg::S_EMIT:     n_state = emit_last ? pds_pkg::S_IDLE : pds_pkg::S_EMIT;
            default:             n_state = pds_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count    = r_count;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_kind     = r_kind;
        n_id       = r_id;
        n_now      = r_now;
        n_status   = r_status;
        n_new_ch   = r_new_ch;
        n_new_iv   = r_new_iv;
        n_new_dl   = r_new_dl;
        n_nfired   = r_nfired;
        n_emit     = r_emit;
        n_delay    = r_delay;
        n_nonempty = r_nonempty;
        fire_we    = 1'b0;
        rd_addr    = '0;
        wr.en      = 1'b0;
        wr.addr    = r_idx[pds_pkg::IDX_W-1:0];
        wr.data    = rd_data;
        unique case (r_state)
            pds_pkg::S_IDLE: begin
                n_kind   = pds_pkg::t_kind'(i_kind);
                n_id     = i_channel_id;
                n_now    = i_now;
                n_idx    = '0;
                n_nfired = '0;
                n_emit   = '0;
                n_new_ch = i_channel_id;
                n_new_iv = i_interval_minutes;
                n_status = pds_pkg::ST_OK;
                if (pds_pkg::t_kind'(i_kind) == pds_pkg::K_NONE ||
                    (pds_pkg::t_kind'(i_kind) == pds_pkg::K_ADD && i_interval_minutes == '0)) begin
                    n_status = pds_pkg::ST_IGNORED;
                end
            end
            pds_pkg::S_FIND_RD: begin
                rd_addr = r_idx[pds_pkg::IDX_W-1:0];
                if (!(r_idx < r_count)) begin
                    if (r_kind == pds_pkg::K_REMOVE) begin
                        n_status = pds_pkg::ST_IGNORED;
                    end else if (r_count >= pds_pkg::SLOTS_CNT) begin
                        n_status = pds_pkg::ST_FULL;
                    end
                end
            end
            pds_pkg::S_FIND_CHK: begin
                if (rd_data.channel == r_id) begin
                    if (r_kind == pds_pkg::K_ADD) begin
                        n_status = pds_pkg::ST_IGNORED;
                    end
                end else begin
                    n_idx = r_idx + pds_pkg::t_cnt'(1);
                end
            end
            pds_pkg::S_REM_RD: begin
                rd_addr = pds_pkg::t_idx'(r_idx + pds_pkg::t_cnt'(1));
                if (!(r_idx + pds_pkg::t_cnt'(1) < r_count)) begin
                    n_count = r_count - pds_pkg::t_cnt'(1);
                end
            end
            pds_pkg::S_REM_WR: begin
                // pull the next entry down one slot
                wr.en = 1'b1;
                n_idx = r_idx + pds_pkg::t_cnt'(1);
            end
            pds_pkg::S_MUL: ;
            pds_pkg::S_SUM: begin
                n_new_dl = sum[48] ? '1 : sum[47:0];
                n_idx    = '0;
            end
            pds_pkg::S_INS_RD: begin
                rd_addr = r_idx[pds_pkg::IDX_W-1:0];
                if (!(r_idx < r_count)) begin
                    n_pos = r_idx;
                end
            end
            pds_pkg::S_INS_CHK: begin
                // new entry goes after its equals
                if (r_new_dl < rd_data.deadline) begin
                    n_pos = r_idx;
                    n_idx = r_count;
                end else begin
                    n_idx = r_idx + pds_pkg::t_cnt'(1);
                end
            end
            pds_pkg::S_SHF_RD: begin
                rd_addr = pds_pkg::t_idx'(r_idx - pds_pkg::t_cnt'(1));
            end
            pds_pkg::S_SHF_WR: begin
                wr.en = 1'b1;
                n_idx = r_idx - pds_pkg::t_cnt'(1);
            end
            pds_pkg::S_INS_WR: begin
                wr.en            = 1'b1;
                wr.addr          = r_pos[pds_pkg::IDX_W-1:0];
                wr.data.channel  = r_new_ch;
                wr.data.interval = r_new_iv;
                wr.data.deadline = r_new_dl;
                n_count          = r_count + pds_pkg::t_cnt'(1);
            end
            pds_pkg::S_TICK_RD: begin
                rd_addr = '0;
            end
            pds_pkg::S_TICK_CHK: begin
                if (rd_data.deadline < r_now) begin
                    n_new_ch = rd_data.channel;
                    n_new_iv = rd_data.interval;
                    n_idx    = '0;
                    if (r_nfired < pds_pkg::MAX_NF) begin
                        fire_we  = 1'b1;
                        n_nfired = r_nfired + pds_pkg::t_nf'(1);
                    end
                end
            end
            pds_pkg::S_FIN_RD: begin
                rd_addr = '0;
                if (r_count == '0) begin
                    n_nonempty = 1'b0;
                    n_delay    = '0;
                end
            end
            pds_pkg::S_FIN_CHK: begin
                n_nonempty = 1'b1;
                n_delay    = (r_now > rd_data.deadline) ? 48'd1 : rd_data.deadline - r_now;
            end
            pds_pkg::S_EMIT: begin
                n_emit = r_emit + pds_pkg::t_nf'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pds_pkg::S_IDLE;
            r_count <= '0;
            r_tpm   <= pds_pkg::TPM_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_tpm <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_kind     <= n_kind;
        r_id       <= n_id;
        r_now      <= n_now;
        r_status   <= n_status;
        r_new_ch   <= n_new_ch;
        r_new_iv   <= n_new_iv;
        r_new_dl   <= n_new_dl;
        r_nfired   <= n_nfired;
        r_emit     <= n_emit;
        r_delay    <= n_delay;
        r_nonempty <= n_nonempty;
        r_prod     <= 48'(r_new_iv) * 48'(r_tpm);
        if (fire_we) begin
            r_fired[r_nfired[pds_pkg::FI_W-1:0]] <= rd_data.channel;
        end
    end

    // outputs
    always_comb begin
        busy             = (r_state != pds_pkg::S_IDLE);
        o_valid          = (r_state == pds_pkg::S_EMIT);
        o_status         = r_status;
        o_fired          = (r_nfired != '0);
        o_fired_channel  = (r_nfired != '0) ? r_fired[r_emit[pds_pkg::FI_W-1:0]] : 8'd0;
        o_queue_nonempty = r_nonempty;
        o_next_delay     = r_delay;
        o_last           = emit_last;
    end

    `PDS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= pds_pkg::SLOTS_CNT)
    `PDS_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `PDS_ASSERT_NXT(a_burst_end, i_clk, i_rst_n, o_valid && o_last, !o_valid)
    `PDS_ASSERT_IMP(a_fired_ok, i_clk, i_rst_n, o_valid && o_fired, o_status == pds_pkg::ST_OK)
endmodule

// File: sim/tb_periodic_deadline_scheduler.sv
// ----------------------------------------------------------------------------
// Periodic deadline scheduler testbench
// Directed table then random add/remove/tick/none traffic; each result is
// checked per field against a behavioural model of the sorted channel table.
// ----------------------------------------------------------------------------
module tb_periodic_deadline_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_kind = '0;
    logic [7:0]  i_channel_id = '0;
    logic [15:0] i_interval_minutes = '0;
    logic [47:0] i_now = '0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic        o_fired;
    logic [7:0]  o_fired_channel;
    logic        o_queue_nonempty;
    logic [47:0] o_next_delay;
    logic        o_last;

    localparam logic [47:0] DL_MAX = 48'hFFFF_FFFF_FFFF;

    periodic_deadline_scheduler uut (.*);

    always #1 i_clk = ~i_clk;

    typedef struct packed {
        logic [1:0]  status;
        logic        fired;
        logic [7:0]  channel;
        logic        nonempty;
        logic [47:0] delay;
        logic        last;
    } t_result;

    typedef struct {
        pds_pkg::t_kind kind;
        logic [7:0]  id;
        logic [15:0] minutes;
        logic [47:0] now;
        logic        typed;
        logic [1:0]  status;
        logic        nonempty;
        logic [47:0] delay;
    } t_row;

    // scheduler model
    logic [31:0] tpm;
    logic [7:0]  tbl_id[pds_pkg::SLOTS];
    logic [15:0] tbl_min[pds_pkg::SLOTS];
    logic [47:0] tbl_dl[pds_pkg::SLOTS];
    int          tbl_n;
    t_result     pending[$];
    int          errors = 0;
    int          results_seen = 0;
    int          fired_seen = 0;

    function automatic logic [47:0] due_after(logic [47:0] now, logic [15:0] m);
        logic [80:0] d;
        d = {33'd0, now} + 81'(m) * 81'(tpm);
        return (d > 81'(DL_MAX)) ? DL_MAX : d[47:0];
    endfunction

    function automatic int locate(logic [7:0] id);
        for (int i = 0; i < tbl_n; i++) if (tbl_id[i] == id) return i;
        return -1;
    endfunction

    function automatic void drop_slot(int p);
        for (int i = p; i + 1 < tbl_n; i++) begin
            tbl_id[i] = tbl_id[i+1];
            tbl_min[i] = tbl_min[i+1];
            tbl_dl[i] = tbl_dl[i+1];
        end
        tbl_n--;
    endfunction

    function automatic void place(logic [7:0] id, logic [15:0] m, logic [47:0] dl);
        int p;
        p = 0;
        while (p < tbl_n && !(dl < tbl_dl[p])) p++;
        for (int i = tbl_n; i > p; i--) begin
            tbl_id[i] = tbl_id[i-1];
            tbl_min[i] = tbl_min[i-1];
            tbl_dl[i] = tbl_dl[i-1];
        end
        tbl_id[p] = id;
        tbl_min[p] = m;
        tbl_dl[p] = dl;
        tbl_n++;
    endfunction

    function automatic void schedule_item(pds_pkg::t_kind k, logic [7:0] id, logic [15:0] m,
                                          logic [47:0] now);
        logic [7:0]  fired_ids[$];
        logic [1:0]  st;
        logic        ne;
        logic [47:0] dly;
        logic [7:0]  c;
        logic [15:0] cm;
        t_result     r;
        st = pds_pkg::ST_OK;
        ne = 1'b0;
        dly = '0;
        case (k)
            pds_pkg::K_ADD: begin
                if (m == 0 || locate(id) >= 0) st = pds_pkg::ST_IGNORED;
                else if (tbl_n >= pds_pkg::SLOTS) st = pds_pkg::ST_FULL;
                else place(id, m, due_after(now, m));
            end
            pds_pkg::K_REMOVE: begin
                if (locate(id) < 0) st = pds_pkg::ST_IGNORED;
                else drop_slot(locate(id));
            end
            pds_pkg::K_TICK: begin
                while (tbl_n > 0 && tbl_dl[0] < now) begin
                    c = tbl_id[0];
                    cm = tbl_min[0];
                    drop_slot(0);
                    place(c, cm, due_after(now, cm));
                    if (fired_ids.size() < pds_pkg::MAX_RES) fired_ids.push_back(c);
                end
            end
            default: st = pds_pkg::ST_IGNORED;
        endcase
        if (tbl_n > 0) begin
            ne = 1'b1;
            dly = (now > tbl_dl[0]) ? 48'd1 : tbl_dl[0] - now;
        end
        if (fired_ids.size() == 0) begin
            r = '{st, 1'b0, 8'd0, ne, dly, 1'b1};
            pending.push_back(r);
        end else begin
            foreach (fired_ids[i]) begin
                r = '{st, 1'b1, fired_ids[i], ne, dly, i == fired_ids.size() - 1};
                pending.push_back(r);
            end
        end
    endfunction

    // results
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (o_fired) fired_seen++;
            if (pending.size() == 0) begin
                $error("unexpected result status=%0d", o_status);
                errors++;
            end else begin
                exp_r = pending.pop_front();
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_status);
                    errors++;
                end
                if (o_fired !== exp_r.fired) begin
                    $error("fired: expected %0d, got %0d", exp_r.fired, o_fired);
                    errors++;
                end
                if (o_fired_channel !== exp_r.channel) begin
                    $error("fired_channel: expected %0d, got %0d", exp_r.channel,
                           o_fired_channel);
                    errors++;
                end
                if (o_queue_nonempty !== exp_r.nonempty) begin
                    $error("queue_nonempty: expected %0d, got %0d", exp_r.nonempty,
                           o_queue_nonempty);
                    errors++;
                end
                if (o_next_delay !== exp_r.delay) begin
                    $error("next_delay: expected %0d, got %0d", exp_r.delay,
                           o_next_delay);
                    errors++;
                end
                if (o_last !== exp_r.last) begin
                    $error("last: expected %0d, got %0d", exp_r.last, o_last);
                    errors++;
                end
            end
        end
    end

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
        repeat (n) @(negedge i_clk);
    endtask

    // present one transaction; start is held until accepted
    task automatic send(pds_pkg::t_kind k, logic [7:0] id, logic [15:0] m, logic [47:0] now,
                        bit gaps);
        start <= 1'b1;
        i_kind <= k;
        i_channel_id <= id;
        i_interval_minutes <= m;
        i_now <= now;
        do @(posedge i_clk); while (busy);
        schedule_item(k, id, m, now);
        @(negedge i_clk);
        if (gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            idle_gap();
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while ((pending.size() != 0 || busy) && guard < 20000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_tpm(logic [31:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tpm = v;
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    t_row rows[] = '{
        '{pds_pkg::K_TICK,   8'd0,   16'd0,     48'd0,  1'b1, pds_pkg::ST_OK,      1'b0, 48'd0},
        '{pds_pkg::K_REMOVE, 8'd7,   16'd0,     48'd0,  1'b1, pds_pkg::ST_IGNORED, 1'b0, 48'd0},
        '{pds_pkg::K_NONE,   8'd0,   16'd0,     48'd5,  1'b1, pds_pkg::ST_IGNORED, 1'b0, 48'd0},
        '{pds_pkg::K_ADD,    8'd1,   16'd0,     48'd0,  1'b1, pds_pkg::ST_IGNORED, 1'b0, 48'd0},
        '{pds_pkg::K_ADD,    8'd0,   16'd1,     48'd0,  1'b1, pds_pkg::ST_OK,      1'b1, 48'd10},
        '{pds_pkg::K_ADD,    8'd255, 16'd65535, DL_MAX, 1'b1, pds_pkg::ST_OK,      1'b1, 48'd1},
        '{pds_pkg::K_ADD,    8'd0,   16'd2,     48'd0,  1'b1, pds_pkg::ST_IGNORED, 1'b1, 48'd10},
        '{pds_pkg::K_ADD,    8'd9,   16'd1,     48'd0,  1'b0, pds_pkg::ST_OK,      1'b0, 48'd0},
        '{pds_pkg::K_TICK,   8'd0,   16'd0,     48'd10, 1'b0, pds_pkg::ST_OK,      1'b0, 48'd0},
        '{pds_pkg::K_TICK,   8'd0,   16'd0,     48'd11, 1'b0, pds_pkg::ST_OK,      1'b0, 48'd0},
        '{pds_pkg::K_REMOVE, 8'd255, 16'd0,     48'd11, 1'b0, pds_pkg::ST_OK,      1'b0, 48'd0},
        '{pds_pkg::K_TICK,   8'd0,   16'd0,     48'd50, 1'b0, pds_pkg::ST_OK,      1'b0, 48'd0},
        '{pds_pkg::K_REMOVE, 8'd0,   16'd0,     48'd50, 1'b0, pds_pkg::ST_OK,      1'b0, 48'd0},
        '{pds_pkg::K_REMOVE, 8'd9,   16'd0,     48'd50, 1'b0, pds_pkg::ST_OK,      1'b0, 48'd0}
    };

    initial begin
        logic [47:0] clock_now;
        t_result     typed_r;
        int          items;
        tpm = pds_pkg::TPM_RESET;
        tbl_n = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // run the table with a short minute so deadlines are easy to read
        write_tpm(32'd10);
        foreach (rows[i]) begin
            send(rows[i].kind, rows[i].id, rows[i].minutes, rows[i].now, 1'b0);
            if (rows[i].typed) begin
                // overwrite the prediction with the hand-typed value
                typed_r = pending[$];
                typed_r.status = rows[i].status;
                typed_r.nonempty = rows[i].nonempty;
                typed_r.delay = rows[i].delay;
                pending[$] = typed_r;
            end
        end
        // fill the table past capacity, saturating deadlines at the top minute
        write_tpm(32'hFFFF_FFFF);
        for (int i = 0; i < pds_pkg::SLOTS + 2; i++)
            send(pds_pkg::K_ADD, 8'(i + 100), 16'hFFFF, 48'hFFFF_0000_0000, 1'b0);
        write_tpm(32'd1);
        for (int i = 0; i < pds_pkg::SLOTS; i++)
            send(pds_pkg::K_REMOVE, 8'(i + 100), 16'd0, 48'd0, 1'b0);
        items = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_tpm(32'd1);
                1: write_tpm(32'd1000);
                2: write_tpm(32'($urandom_range(2, 500)));
                default: write_tpm(pds_pkg::TPM_RESET);
            endcase
            clock_now = (ph == 3) ? rand48() >> 1 : 48'($urandom_range(0, 1000));
            for (int n = 0; n < 50; n++) begin
                int sel;
                logic [15:0] mins;
                sel = $urandom_range(0, 19);
                mins = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                     : 16'($urandom_range(0, 20));
                if (ph == 3 && $urandom_range(0, 7) == 0) clock_now = rand48();
                if (sel < 9)
                    send(pds_pkg::K_ADD, 8'($urandom_range(0, 23)), mins, clock_now, 1'b1);
                else if (sel < 12)
                    send(pds_pkg::K_REMOVE, ($urandom_range(0, 9) == 0) ? 8'($urandom)
                         : 8'($urandom_range(0, 23)), 16'($urandom), clock_now, 1'b1);
                else if (sel < 19) begin
                    clock_now = clock_now + 48'($urandom_range(0, 40)) * 48'(tpm);
                    send(pds_pkg::K_TICK, 8'($urandom), 16'($urandom), clock_now, 1'b1);
                end else
                    send(pds_pkg::K_NONE, 8'($urandom), 16'($urandom), rand48(), 1'b1);
                items++;
            end
        end
        drain();
        $display("Ran %0d random transactions over four minute settings.", items);
        $display("Checked %0d results, %0d of them reporting fired channels.",
                 results_seen, fired_seen);
        if (errors == 0 && pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/pds_pkg.sv
rtl/pds_slot_ram.sv
rtl/periodic_deadline_scheduler.sv
sim/tb_periodic_deadline_scheduler.sv
